// ===== rtl/core/acl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package acl_pkg;

    // Table geometry
    localparam int RULE_SLOTS = 64;
    localparam int SLOT_W     = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int CNT_W      = $clog2(RULE_SLOTS + 1);

    // Fixed port field widths
    localparam int TGT_W      = 6;
    localparam int IDX_OUT_W  = 6;
    localparam int FREE_OUT_W = 7;

    // Width wide enough to compare a target index against the slot count
    localparam int TGT_CMP_W  = (SLOT_W + 1 > TGT_W + 1) ? SLOT_W + 1 : TGT_W + 1;

    // Request codes
    typedef enum logic [1:0] {
        FN_ADD    = 2'd0,
        FN_DELETE = 2'd1,
        FN_CLEAR  = 2'd2,
        FN_COMMIT = 2'd3
    } func_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EXISTS    = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // One stored rule, as held in the rule memory
    typedef struct packed {
        logic [47:0] src_mac;
        logic [47:0] dst_mac;
        logic [37:0] src_prefix;
        logic [37:0] dst_prefix;
        logic [63:0] ports;       // sport range, dport range
        logic [17:0] proto_flag;  // proto range, action, log
        logic [63:0] start_time;
        logic [63:0] end_time;
    } rule_t;

    localparam int RULE_W = $bits(rule_t);

endpackage

`default_nettype wire

// ===== rtl/core/acl_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface acl_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [5:0]  target_index;
    logic [47:0] src_mac;
    logic [47:0] dst_mac;
    logic [37:0] src_ip_prefix;
    logic [37:0] dst_ip_prefix;
    logic [31:0] sport_range;
    logic [31:0] dport_range;
    logic [15:0] proto_range;
    logic [63:0] window_start;
    logic [63:0] window_end;
    logic [1:0]  action_and_log;

    modport source (
        output valid, func, target_index, src_mac, dst_mac, src_ip_prefix,
               dst_ip_prefix, sport_range, dport_range, proto_range,
               window_start, window_end, action_and_log,
        input  ready
    );

    modport sink (
        input  valid, func, target_index, src_mac, dst_mac, src_ip_prefix,
               dst_ip_prefix, sport_range, dport_range, proto_range,
               window_start, window_end, action_and_log,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/acl_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface acl_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [5:0] assigned_index;
    logic [6:0] free_count;
    logic       uncommitted;

    modport source (
        output valid, status, assigned_index, free_count, uncommitted,
        input  ready
    );

    modport sink (
        input  valid, status, assigned_index, free_count, uncommitted,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/acl_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module acl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/acl_rule_table_manager.sv =====
// Packet filter rule table manager.
// req channel: one request per transaction (add, delete by index, clear all,
// commit) with the rule fields. rsp channel: one result per request with
// status, slot of an added rule, free slot count and the uncommitted flag.
// Rules live in a single-port-read rule memory; slot used bits, the free
// count and the uncommitted flag are flip-flops.
// Flow: an add reads the rule memory one slot per cycle to look for a
// duplicate and the lowest free slot, then a drain step empties the read
// pipe and a decide step decides and, on success, writes the rule. Delete,
// clear and commit go from acceptance straight to the result step. One
// request is in work at a time; req.ready rises again as the result is
// handed to the output register.
// The result sits in an output register; while rsp is stalled the next
// request is still accepted and worked, and waits before the output register
// until it frees up.
// Reset: every slot free, free count RULE_SLOTS, uncommitted clear, no
// result pending. The rule memory is not cleared; only used slots are compared.
`timescale 1ns / 1ps
`default_nettype none

module acl_rule_table_manager (
    input  logic      clk,
    input  logic      rst_n,
    acl_req_if.sink   req,
    acl_rsp_if.source rsp
);
    import acl_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_DRAIN  = 5'b00100,
        S_DECIDE = 5'b01000,
        S_RESP   = 5'b10000
    } state_t;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RULE_SLOTS - 1);

    // Control state
    state_t                  state_reg, state_next;
    logic [RULE_SLOTS-1:0]   used_reg, used_next;
    logic [CNT_W-1:0]        free_cnt_reg, free_cnt_next;
    logic                    dirty_reg, dirty_next;
    logic [SLOT_W-1:0]       scan_idx_reg, scan_idx_next;
    logic                    cmp_vld_reg, cmp_vld_next;
    logic                    cmp_used_reg, cmp_used_next;
    logic [SLOT_W-1:0]       cmp_idx_reg, cmp_idx_next;
    logic                    dup_reg, dup_next;
    logic                    found_reg, found_next;
    logic                    out_valid_reg, out_valid_next;

    // Payload
    rule_t                   rule_reg, rule_next;
    logic [SLOT_W-1:0]       first_reg, first_next;
    status_t                 res_status_reg, res_status_next;
    logic [IDX_OUT_W-1:0]    res_index_reg, res_index_next;
    status_t                 out_status_reg, out_status_next;
    logic [IDX_OUT_W-1:0]    out_index_reg, out_index_next;
    logic [FREE_OUT_W-1:0]   out_free_reg, out_free_next;
    logic                    out_dirty_reg, out_dirty_next;

    // Rule memory port
    logic                    ram_we;
    logic [RULE_W-1:0]       ram_rdata;

    rule_t                   rule_in;
    logic [SLOT_W-1:0]       tgt_slot;
    logic                    tgt_in_range;
    logic                    cmp_match;
    logic                    out_free_slot;

    // Request fields packed the way a rule is stored
    always_comb
    begin
        rule_in.src_mac    = req.src_mac;
        rule_in.dst_mac    = req.dst_mac;
        rule_in.src_prefix = req.src_ip_prefix;
        rule_in.dst_prefix = req.dst_ip_prefix;
        rule_in.ports      = {req.sport_range, req.dport_range};
        rule_in.proto_flag = {req.proto_range, req.action_and_log};
        rule_in.start_time = req.window_start;
        rule_in.end_time   = req.window_end;
    end

    assign tgt_slot     = SLOT_W'(req.target_index);
    assign tgt_in_range = TGT_CMP_W'(req.target_index) < TGT_CMP_W'(RULE_SLOTS);
    assign cmp_match    = (ram_rdata == RULE_W'(rule_reg));
    assign out_free_slot = !out_valid_reg || rsp.ready;

    acl_ram #(
        .WIDTH (RULE_W),
        .DEPTH (RULE_SLOTS)
    ) u_rule_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (first_reg),
        .wdata (RULE_W'(rule_reg)),
        .raddr (scan_idx_reg),
        .rdata (ram_rdata)
    );

    // Next-state logic
    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        free_cnt_next   = free_cnt_reg;
        dirty_next      = dirty_reg;
        scan_idx_next   = scan_idx_reg;
        dup_next        = dup_reg;
        found_next      = found_reg;
        rule_next       = rule_reg;
        first_next      = first_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        out_free_next   = out_free_reg;
        out_dirty_next  = out_dirty_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        ram_we          = 1'b0;

        // Read pipe: memory data lines up with the slot issued last cycle
        cmp_vld_next  = (state_reg == S_SCAN);
        cmp_idx_next  = scan_idx_reg;
        cmp_used_next = used_reg[scan_idx_reg];

        // Compare stage: duplicate and lowest free slot
        if (cmp_vld_reg && cmp_used_reg && cmp_match)
        begin
            dup_next = 1'b1;
        end
        if (cmp_vld_reg && !cmp_used_reg && !found_reg)
        begin
            found_next = 1'b1;
            first_next = cmp_idx_reg;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    res_status_next = ST_OK;
                    res_index_next  = '0;
                    state_next      = S_RESP;
                    case (func_t'(req.func))
                        FN_ADD:
                        begin
                            rule_next     = rule_in;
                            scan_idx_next = '0;
                            dup_next      = 1'b0;
                            found_next    = 1'b0;
                            state_next    = S_SCAN;
                        end
                        FN_DELETE:
                        begin
                            if (tgt_in_range && used_reg[tgt_slot])
                            begin
                                used_next[tgt_slot] = 1'b0;
                                free_cnt_next       = free_cnt_reg + 1'b1;
                                dirty_next          = 1'b1;
                            end
                            else
                            begin
                                res_status_next = ST_NOT_FOUND;
                            end
                        end
                        FN_CLEAR:
                        begin
                            used_next     = '0;
                            free_cnt_next = CNT_W'(RULE_SLOTS);
                            dirty_next    = 1'b1;
                        end
                        FN_COMMIT:
                        begin
                            dirty_next = 1'b0;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (scan_idx_reg == LAST_SLOT)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end

            S_DRAIN:
            begin
                state_next = S_DECIDE;
            end

            // Outcome of an add; store the rule on success
            S_DECIDE:
            begin
                res_index_next = '0;
                if (free_cnt_reg == '0 || !found_reg)
                begin
                    res_status_next = ST_FULL;
                end
                else if (dup_reg)
                begin
                    res_status_next = ST_EXISTS;
                end
                else
                begin
                    res_status_next      = ST_OK;
                    res_index_next       = IDX_OUT_W'(first_reg);
                    ram_we               = 1'b1;
                    used_next[first_reg] = 1'b1;
                    free_cnt_next        = free_cnt_reg - 1'b1;
                    dirty_next           = 1'b1;
                end
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (out_free_slot)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_index_next  = res_index_reg;
                    out_free_next   = FREE_OUT_W'(free_cnt_reg);
                    out_dirty_next  = dirty_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            free_cnt_reg  <= CNT_W'(RULE_SLOTS);
            dirty_reg     <= 1'b0;
            scan_idx_reg  <= '0;
            cmp_vld_reg   <= 1'b0;
            cmp_used_reg  <= 1'b0;
            cmp_idx_reg   <= '0;
            dup_reg       <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            free_cnt_reg  <= free_cnt_next;
            dirty_reg     <= dirty_next;
            scan_idx_reg  <= scan_idx_next;
            cmp_vld_reg   <= cmp_vld_next;
            cmp_used_reg  <= cmp_used_next;
            cmp_idx_reg   <= cmp_idx_next;
            dup_reg       <= dup_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rule_reg       <= rule_next;
        first_reg      <= first_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
        out_free_reg   <= out_free_next;
        out_dirty_reg  <= out_dirty_next;
    end

    // Ports
    assign req.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.assigned_index = out_index_reg;
    assign rsp.free_count     = out_free_reg;
    assign rsp.uncommitted    = out_dirty_reg;

    // Free count always agrees with the used bits
    a_free_count: assert property (@(posedge clk) disable iff (!rst_n)
        free_cnt_reg == CNT_W'($countones(~used_reg)))
        else $error("free count out of step with used bits");

    // A rule is only ever written into a free slot, at the decision step
    a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_DECIDE && !used_reg[first_reg] && found_reg))
        else $error("rule written into a used slot");

    // Last slot read leads to the drain step with its compare pending
    a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && scan_idx_reg == LAST_SLOT)
        |=> (state_reg == S_DRAIN && cmp_vld_reg && cmp_idx_reg == LAST_SLOT))
        else $error("scan did not finish cleanly");

endmodule

`default_nettype wire
